// File: rtl/assert_macros.svh
// Assertion macros for the RTL files that check themselves.
// No dependencies; taken in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/sme_pkg.sv
// Package for the stack machine executor: opcodes, status codes, defaults.
// No dependencies.
package sme_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 256;
  localparam int unsigned IP_BITS_DEF     = 16;

  localparam int unsigned KIND_W   = 5;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned NEXTIP_W = 16;

  localparam logic [KIND_W-1:0] KIND_PUSH  = 5'd0;
  localparam logic [KIND_W-1:0] KIND_POP   = 5'd1;
  localparam logic [KIND_W-1:0] KIND_ADD   = 5'd2;
  localparam logic [KIND_W-1:0] KIND_SUB   = 5'd3;
  localparam logic [KIND_W-1:0] KIND_PEEK  = 5'd4;
  localparam logic [KIND_W-1:0] KIND_HALT  = 5'd5;
  localparam logic [KIND_W-1:0] KIND_LT    = 5'd6;
  localparam logic [KIND_W-1:0] KIND_GT    = 5'd7;
  localparam logic [KIND_W-1:0] KIND_LE    = 5'd8;
  localparam logic [KIND_W-1:0] KIND_GE    = 5'd9;
  localparam logic [KIND_W-1:0] KIND_EQ    = 5'd10;
  localparam logic [KIND_W-1:0] KIND_NE    = 5'd11;
  localparam logic [KIND_W-1:0] KIND_LOAD  = 5'd12;
  localparam logic [KIND_W-1:0] KIND_STORE = 5'd13;
  localparam logic [KIND_W-1:0] KIND_JZ    = 5'd14;
  localparam logic [KIND_W-1:0] KIND_J1    = 5'd15;
  localparam logic [KIND_W-1:0] KIND_JMP   = 5'd16;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVER  = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;
  localparam logic [1:0] ST_INDEX = 2'd3;

  // Two-operand ops: pop right, pop left, push result.
  function automatic logic is_binary(input logic [KIND_W-1:0] k);
    return (k == KIND_ADD) || (k == KIND_SUB) || (k == KIND_LT) || (k == KIND_GT) ||
           (k == KIND_LE) || (k == KIND_GE) || (k == KIND_EQ) || (k == KIND_NE);
  endfunction

endpackage

// File: rtl/sme_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module sme_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: rtl/stack_machine_executor_top.sv
// Stack machine executor top level: sequencer, shared ALU, stack RAM.
// Depends on sme_pkg, sme_ram and assert_macros.svh.
//
// channel   direction  beat marked by       payload
// command   in         start & !busy        kind, operand
// result    out        done (one cycle)     next_ip, top_valid, top_value, halted, status
//
// After reset the stack RAM is zeroed, one entry a cycle, with busy high.
// Per instruction: add, sub and compares go through CHECK, RD1 and RD2; peek, load,
// store, jz and j1 through CHECK and RD1; the rest, errors, empty peeks and a halted
// machine end in CHECK. Reads share the single RAM port; the ALU result is written last.
// The result beat comes the cycle after the last step; the receiver cannot stall.
// Reset is synchronous; busy stays high from reset through the clearing pass.
module stack_machine_executor_top
  import sme_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned IP_BITS     = IP_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [KIND_W-1:0]          kind,
  input  logic signed [DATA_W-1:0]   operand,
  output logic                       busy,
  output logic                       done,
  output logic [NEXTIP_W-1:0]        next_ip,
  output logic                       top_valid,
  output logic signed [DATA_W-1:0]   top_value,
  output logic                       halted,
  output logic [1:0]                 status
);

`include "assert_macros.svh"

  localparam int unsigned AW  = $clog2(STACK_DEPTH);
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_RD1,
    S_RD2
  } state_t;

  state_t              state;
  logic [AW-1:0]       clr_addr;
  logic [SPW-1:0]      sp;
  logic [IP_BITS-1:0]  ip;
  logic                run;
  logic [KIND_W-1:0]   kind_r;
  logic [DATA_W-1:0]   op_r;
  logic [DATA_W-1:0]   r_val;

  logic                ram_en;
  logic                ram_we;
  logic [AW-1:0]       ram_addr;
  logic [DATA_W-1:0]   ram_wdata;
  logic [DATA_W-1:0]   ram_rdata;

  logic                full;
  logic                empty;
  logic                idx_ok;
  logic [1:0]          chk_status;
  logic [DATA_W-1:0]   alu_y;
  logic [IP_BITS-1:0]  ip_inc;
  logic [IP_BITS-1:0]  ip_jump;
  logic                jump_hit;

  assign full    = (sp == SPW'(STACK_DEPTH));
  assign empty   = (sp == '0);
  assign idx_ok  = !op_r[DATA_W-1] && (op_r < DATA_W'(STACK_DEPTH));
  assign ip_inc  = ip + IP_BITS'(1);
  assign ip_jump = ip + IP_BITS'(op_r);
  assign jump_hit = (kind_r == KIND_JZ) ? (ram_rdata == '0) : (ram_rdata == DATA_W'(1));

  // Error checks on the latched instruction; a halted machine reports ok.
  always_comb begin
    chk_status = ST_OK;
    if (run) begin
      unique case (kind_r)
        KIND_PUSH:                    chk_status = full ? ST_OVER : ST_OK;
        KIND_POP, KIND_JZ, KIND_J1:   chk_status = empty ? ST_UNDER : ST_OK;
        KIND_ADD, KIND_SUB, KIND_LT, KIND_GT, KIND_LE, KIND_GE, KIND_EQ, KIND_NE:
          chk_status = (sp < SPW'(2)) ? ST_UNDER : ST_OK;
        KIND_LOAD:
          chk_status = full ? ST_OVER : (idx_ok ? ST_OK : ST_INDEX);
        KIND_STORE:
          chk_status = empty ? ST_UNDER : (idx_ok ? ST_OK : ST_INDEX);
        default:                      chk_status = ST_OK;
      endcase
    end
  end

  // Shared ALU: left operand from the second read, right from the first.
  always_comb begin
    unique case (kind_r)
      KIND_ADD: alu_y = ram_rdata + r_val;
      KIND_SUB: alu_y = ram_rdata - r_val;
      KIND_LT:  alu_y = DATA_W'($signed(ram_rdata) <  $signed(r_val));
      KIND_GT:  alu_y = DATA_W'($signed(ram_rdata) >  $signed(r_val));
      KIND_LE:  alu_y = DATA_W'($signed(ram_rdata) <= $signed(r_val));
      KIND_GE:  alu_y = DATA_W'($signed(ram_rdata) >= $signed(r_val));
      KIND_EQ:  alu_y = DATA_W'(ram_rdata == r_val);
      default:  alu_y = DATA_W'(ram_rdata != r_val);
    endcase
  end

  // Stack RAM port steering.
  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = AW'(sp - SPW'(1));
    ram_wdata = ram_rdata;
    unique case (state)
      S_CLEAR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_addr;
        ram_wdata = '0;
      end
      S_CHECK: begin
        if (run && chk_status == ST_OK) begin
          if (kind_r == KIND_PUSH) begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = AW'(sp);
            ram_wdata = op_r;
          end else if (kind_r == KIND_LOAD) begin
            ram_en   = 1'b1;
            ram_addr = AW'(op_r);
          end else if (is_binary(kind_r) || kind_r == KIND_STORE || kind_r == KIND_JZ ||
                       kind_r == KIND_J1 || (kind_r == KIND_PEEK && !empty)) begin
            ram_en = 1'b1;
          end
        end
      end
      S_RD1: begin
        if (is_binary(kind_r)) begin
          ram_en   = 1'b1;
          ram_addr = AW'(sp - SPW'(2));
        end else if (kind_r == KIND_LOAD) begin
          ram_en   = 1'b1;
          ram_we   = 1'b1;
          ram_addr = AW'(sp);
        end else if (kind_r == KIND_STORE) begin
          ram_en   = 1'b1;
          ram_we   = 1'b1;
          ram_addr = AW'(op_r);
        end
      end
      S_RD2: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = AW'(sp - SPW'(2));
        ram_wdata = alu_y;
      end
      default: begin
      end
    endcase
  end

  sme_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      sp       <= '0;
      ip       <= '0;
      run      <= 1'b1;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(STACK_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            kind_r <= kind;
            op_r   <= operand;
            state  <= S_CHECK;
          end
        end
        S_CHECK: begin
          top_valid <= 1'b0;
          top_value <= '0;
          status    <= chk_status;
          if (!run || chk_status != ST_OK) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            priority if (kind_r == KIND_PUSH) begin
              sp    <= sp + SPW'(1);
              ip    <= ip_inc;
              done  <= 1'b1;
              state <= S_IDLE;
            end else if (kind_r == KIND_POP) begin
              sp    <= sp - SPW'(1);
              ip    <= ip_inc;
              done  <= 1'b1;
              state <= S_IDLE;
            end else if (kind_r == KIND_HALT) begin
              run   <= 1'b0;
              done  <= 1'b1;
              state <= S_IDLE;
            end else if (kind_r == KIND_JMP) begin
              ip    <= ip_jump;
              done  <= 1'b1;
              state <= S_IDLE;
            end else if (kind_r == KIND_PEEK && empty) begin
              ip    <= ip_inc;
              done  <= 1'b1;
              state <= S_IDLE;
            end else if (is_binary(kind_r) || kind_r == KIND_PEEK || kind_r == KIND_LOAD ||
                         kind_r == KIND_STORE || kind_r == KIND_JZ || kind_r == KIND_J1) begin
              state <= S_RD1;
            end else begin
              // unused opcodes
              ip    <= ip_inc;
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        S_RD1: begin
          r_val <= ram_rdata;
          if (is_binary(kind_r)) begin
            state <= S_RD2;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
            priority if (kind_r == KIND_PEEK) begin
              top_valid <= 1'b1;
              top_value <= ram_rdata;
              ip        <= ip_inc;
            end else if (kind_r == KIND_LOAD) begin
              sp <= sp + SPW'(1);
              ip <= ip_inc;
            end else if (kind_r == KIND_STORE) begin
              sp <= sp - SPW'(1);
              ip <= ip_inc;
            end else begin
              // jz / j1: popped value decides the jump
              sp <= sp - SPW'(1);
              ip <= jump_hit ? ip_jump : ip_inc;
            end
          end
        end
        S_RD2: begin
          sp    <= sp - SPW'(1);
          ip    <= ip_inc;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy    = (state != S_IDLE);
  assign halted  = !run;
  assign next_ip = NEXTIP_W'(ip);

  `ASSERT_NOW(a_done_when_idle, clk, rst, done, !busy)
  `ASSERT_NEXT(a_accept_goes_busy, clk, rst, start && !busy, busy && !done)
  `ASSERT_NOW(a_sp_in_range, clk, rst, 1'b1, sp <= SPW'(STACK_DEPTH))
  `ASSERT_NEXT(a_halt_sticky, clk, rst, halted, halted)

endmodule
